>>> rtl/core/mcpid_pkg.sv
// Shared types and constants for the multi-channel PID controller.
// Used by mcpid_alu, mcpid_csr and multi_channel_pid_controller_unit.
package mcpid_pkg;

   localparam int CFG_W   = 48;
   localparam int WORD_W  = 16;
   localparam int ERR_W   = 17;
   localparam int DW      = 38;
   localparam int MUL_A_W = 18;
   localparam int MUL_P_W = MUL_A_W + WORD_W;
   localparam int CSR_IDX_W = 3;

   localparam logic signed [ERR_W-1:0] SMALL_ERR_HI = 17'sd15;
   localparam logic signed [ERR_W-1:0] SMALL_ERR_LO = -17'sd15;

   localparam logic [CFG_W-1:0] RST_KP     = 48'h0032_0032_0032;
   localparam logic [CFG_W-1:0] RST_KI     = 48'h000F_000F_000F;
   localparam logic [CFG_W-1:0] RST_KD     = 48'h0019_0019_0019;
   localparam logic [CFG_W-1:0] RST_IFLOOR = 48'hFFFF_FFCE_FF9C;
   localparam logic [CFG_W-1:0] RST_DFLOOR = 48'hFFF6_FE70_FE0C;
   localparam logic [CFG_W-1:0] RST_CEIL   = 48'h00C8_1E84_1E83;
   localparam logic [CFG_W-1:0] RST_OFLOOR = 48'h0000_0000_0000;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_KP, REG_KI, REG_KD, REG_IFLOOR, REG_DFLOOR, REG_CEIL, REG_OFLOOR
   } csr_reg_type;

   typedef enum logic [2:0] {
      ALU_ADD, ALU_SUB, ALU_MUL, ALU_MAX, ALU_MIN
   } alu_op_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_MP, ST_MI, ST_IADD, ST_ILO, ST_IHI, ST_DSUB, ST_DMUL,
      ST_D5, ST_D10, ST_DHI, ST_DLO, ST_S1, ST_S2, ST_OLO, ST_OHI
   } state_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] kp;
      logic signed [WORD_W-1:0] ki;
      logic signed [WORD_W-1:0] kd;
      logic signed [WORD_W-1:0] ifloor;
      logic signed [WORD_W-1:0] dfloor;
      logic signed [WORD_W-1:0] ceil;
      logic signed [WORD_W-1:0] ofloor;
   } loop_cfg_type;

   function automatic logic signed [WORD_W-1:0] word_sel(input logic [CFG_W-1:0] tbl,
                                                         input logic [1:0] ch);
      logic signed [WORD_W-1:0] w;
      case (ch)
         2'd0:    w = tbl[15:0];
         2'd1:    w = tbl[31:16];
         default: w = tbl[47:32];
      endcase
      return w;
   endfunction

endpackage

>>> rtl/core/mcpid_alu.sv
// Shared arithmetic unit: add, subtract, 18x16 signed multiply, max and min.
// Depends on mcpid_pkg.
module mcpid_alu
   import mcpid_pkg::*;
(
   input  alu_op_type           op,
   input  logic signed [DW-1:0] a,
   input  logic signed [DW-1:0] b,
   output logic signed [DW-1:0] r
);

   logic signed [MUL_P_W-1:0] prod;

   assign prod = $signed(a[MUL_A_W-1:0]) * $signed(b[WORD_W-1:0]);

   always_comb begin
      unique case (op)
         ALU_ADD: r = a + b;
         ALU_SUB: r = a - b;
         ALU_MUL: r = DW'(prod);
         ALU_MAX: r = (a < b) ? b : a;
         ALU_MIN: r = (a > b) ? b : a;
         default: r = a;
      endcase
   end

endmodule

>>> rtl/core/mcpid_csr.sv
// Configuration tables and per-loop word selection.
// Depends on mcpid_pkg.
module mcpid_csr
   import mcpid_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata,
   input  logic [1:0]           sel_ch,
   output loop_cfg_type         loop_cfg,
   output logic                 gain_wr
);

   logic [CFG_W-1:0] kp_ff, ki_ff, kd_ff, ifl_ff, dfl_ff, ceil_ff, ofl_ff;
   logic [CFG_W-1:0] kp_in, ki_in, kd_in, ifl_in, dfl_in, ceil_in, ofl_in;

   always_comb begin
      kp_in   = kp_ff;
      ki_in   = ki_ff;
      kd_in   = kd_ff;
      ifl_in  = ifl_ff;
      dfl_in  = dfl_ff;
      ceil_in = ceil_ff;
      ofl_in  = ofl_ff;
      gain_wr = 1'b0;
      if (csr_wr_en) begin
         unique case (csr_reg_type'(csr_index))
            REG_KP: begin
               kp_in   = csr_wdata;
               gain_wr = 1'b1;
            end
            REG_KI: begin
               ki_in   = csr_wdata;
               gain_wr = 1'b1;
            end
            REG_KD: begin
               kd_in   = csr_wdata;
               gain_wr = 1'b1;
            end
            REG_IFLOOR: ifl_in  = csr_wdata;
            REG_DFLOOR: dfl_in  = csr_wdata;
            REG_CEIL:   ceil_in = csr_wdata;
            REG_OFLOOR: ofl_in  = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kp_ff   <= RST_KP;
         ki_ff   <= RST_KI;
         kd_ff   <= RST_KD;
         ifl_ff  <= RST_IFLOOR;
         dfl_ff  <= RST_DFLOOR;
         ceil_ff <= RST_CEIL;
         ofl_ff  <= RST_OFLOOR;
      end else begin
         kp_ff   <= kp_in;
         ki_ff   <= ki_in;
         kd_ff   <= kd_in;
         ifl_ff  <= ifl_in;
         dfl_ff  <= dfl_in;
         ceil_ff <= ceil_in;
         ofl_ff  <= ofl_in;
      end
   end

   assign loop_cfg.kp     = word_sel(kp_ff, sel_ch);
   assign loop_cfg.ki     = word_sel(ki_ff, sel_ch);
   assign loop_cfg.kd     = word_sel(kd_ff, sel_ch);
   assign loop_cfg.ifloor = word_sel(ifl_ff, sel_ch);
   assign loop_cfg.dfloor = word_sel(dfl_ff, sel_ch);
   assign loop_cfg.ceil   = word_sel(ceil_ff, sel_ch);
   assign loop_cfg.ofloor = word_sel(ofl_ff, sel_ch);

endmodule

>>> rtl/core/multi_channel_pid_controller_unit.sv
// Multi-channel PID controller top level: sequencer, loop state and result register.
// Depends on mcpid_pkg, mcpid_alu and mcpid_csr.
//
//   channel  direction  beat contents
//   req_     in         channel, target, measured
//   rsp_     out        drive
//   csr_     in         register write (no handshake)
//
// An in-range beat steps one shared ALU (adder, comparator and 18x16
// multiplier) through 15 sequencer states after accept.
// An out-of-range channel returns drive 0 the cycle after accept.
// Synchronous reset clears the integrators, last errors and control state.
// A waiting result holds req_ready low until it is taken or drains that cycle.
module multi_channel_pid_controller_unit
   import mcpid_pkg::*;
#(
   parameter int NUM_LOOPS = 3
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [1:0]               req_channel,
   input  logic [15:0]              req_target,
   input  logic [15:0]              req_measured,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [WORD_W-1:0] rsp_drive,
   input  logic                     csr_wr_en,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [CFG_W-1:0]         csr_wdata
);

   localparam int LW = (NUM_LOOPS > 1) ? $clog2(NUM_LOOPS) : 1;

   state_type                 state_ff, state_in;
   logic [1:0]                ch_ff, ch_in;
   logic signed [ERR_W-1:0]   err_ff, err_in;
   logic signed [DW-1:0]      p_ff, p_in;
   logic signed [DW-1:0]      w_ff, w_in;
   logic signed [WORD_W-1:0]  i_ff, i_in;
   logic signed [WORD_W-1:0]  integ_ff [NUM_LOOPS];
   logic signed [WORD_W-1:0]  integ_in [NUM_LOOPS];
   logic signed [ERR_W-1:0]   last_ff [NUM_LOOPS];
   logic signed [ERR_W-1:0]   last_in [NUM_LOOPS];
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [WORD_W-1:0]  rsp_drive_ff, rsp_drive_in;

   alu_op_type                alu_op;
   logic signed [DW-1:0]      alu_a, alu_b, alu_r;
   loop_cfg_type              loop_cfg;
   logic                      gain_wr;
   logic [LW-1:0]             lidx;
   logic                      small_err;
   logic                      accept;

   mcpid_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .sel_ch    (ch_ff),
      .loop_cfg  (loop_cfg),
      .gain_wr   (gain_wr)
   );

   mcpid_alu u_alu (
      .op (alu_op),
      .a  (alu_a),
      .b  (alu_b),
      .r  (alu_r)
   );

   assign lidx      = ch_ff[LW-1:0];
   assign small_err = (err_ff < SMALL_ERR_HI) && (err_ff > SMALL_ERR_LO);
   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_drive = rsp_drive_ff;

   always_comb begin
      state_in     = state_ff;
      ch_in        = ch_ff;
      err_in       = err_ff;
      p_in         = p_ff;
      w_in         = w_ff;
      i_in         = i_ff;
      integ_in     = integ_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_drive_in = rsp_drive_ff;
      alu_op       = ALU_ADD;
      alu_a        = '0;
      alu_b        = '0;

      unique case (state_ff)
         ST_IDLE: begin
            alu_op = ALU_SUB;
            alu_a  = DW'({1'b0, req_target});
            alu_b  = DW'({1'b0, req_measured});
            if (accept) begin
               ch_in  = req_channel;
               err_in = alu_r[ERR_W-1:0];
               if (int'(req_channel) >= NUM_LOOPS) begin
                  rsp_valid_in = 1'b1;
                  rsp_drive_in = '0;
               end else begin
                  state_in = ST_MP;
               end
            end
         end
         ST_MP: begin
            alu_op   = ALU_MUL;
            alu_a    = DW'(err_ff);
            alu_b    = DW'(loop_cfg.kp);
            p_in     = alu_r;
            state_in = ST_MI;
         end
         ST_MI: begin
            alu_op   = ALU_MUL;
            alu_a    = DW'(err_ff);
            alu_b    = DW'(loop_cfg.ki);
            w_in     = alu_r;
            state_in = ST_IADD;
         end
         ST_IADD: begin
            alu_op   = ALU_ADD;
            alu_a    = DW'(integ_ff[lidx]);
            alu_b    = w_ff;
            w_in     = alu_r;
            state_in = ST_ILO;
         end
         ST_ILO: begin
            alu_op   = ALU_MAX;
            alu_a    = w_ff;
            alu_b    = DW'(loop_cfg.ifloor);
            w_in     = alu_r;
            state_in = ST_IHI;
         end
         ST_IHI: begin
            alu_op          = ALU_MIN;
            alu_a           = w_ff;
            alu_b           = DW'(loop_cfg.ceil);
            i_in            = alu_r[WORD_W-1:0];
            integ_in[lidx]  = alu_r[WORD_W-1:0];
            state_in        = ST_DSUB;
         end
         ST_DSUB: begin
            alu_op        = ALU_SUB;
            alu_a         = DW'(err_ff);
            alu_b         = DW'(last_ff[lidx]);
            w_in          = alu_r;
            last_in[lidx] = err_ff;
            state_in      = ST_DMUL;
         end
         ST_DMUL: begin
            alu_op   = ALU_MUL;
            alu_a    = w_ff;
            alu_b    = DW'(loop_cfg.kd);
            w_in     = alu_r;
            state_in = ST_D5;
         end
         ST_D5: begin
            alu_op   = ALU_ADD;
            alu_a    = w_ff <<< 2;
            alu_b    = w_ff;
            w_in     = alu_r;
            state_in = ST_D10;
         end
         ST_D10: begin
            alu_op   = ALU_ADD;
            alu_a    = w_ff;
            alu_b    = small_err ? w_ff : '0;
            w_in     = alu_r;
            state_in = ST_DHI;
         end
         ST_DHI: begin
            alu_op   = ALU_MIN;
            alu_a    = w_ff;
            alu_b    = DW'(loop_cfg.ceil);
            w_in     = alu_r;
            state_in = ST_DLO;
         end
         ST_DLO: begin
            alu_op   = ALU_MAX;
            alu_a    = w_ff;
            alu_b    = DW'(loop_cfg.dfloor);
            w_in     = alu_r;
            state_in = ST_S1;
         end
         ST_S1: begin
            alu_op   = ALU_ADD;
            alu_a    = p_ff;
            alu_b    = w_ff;
            p_in     = alu_r;
            state_in = ST_S2;
         end
         ST_S2: begin
            alu_op   = ALU_ADD;
            alu_a    = p_ff;
            alu_b    = DW'(i_ff);
            w_in     = alu_r;
            state_in = ST_OLO;
         end
         ST_OLO: begin
            alu_op   = ALU_MAX;
            alu_a    = w_ff;
            alu_b    = DW'(loop_cfg.ofloor);
            w_in     = alu_r;
            state_in = ST_OHI;
         end
         ST_OHI: begin
            alu_op       = ALU_MIN;
            alu_a        = w_ff;
            alu_b        = DW'(loop_cfg.ceil);
            rsp_valid_in = 1'b1;
            rsp_drive_in = alu_r[WORD_W-1:0];
            state_in     = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase

      if (gain_wr) begin
         for (int k = 0; k < NUM_LOOPS; k++) begin
            integ_in[k] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < NUM_LOOPS; k++) begin
            integ_ff[k] <= '0;
            last_ff[k]  <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         integ_ff     <= integ_in;
         last_ff      <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      ch_ff        <= ch_in;
      err_ff       <= err_in;
      p_ff         <= p_in;
      w_ff         <= w_in;
      i_ff         <= i_in;
      rsp_drive_ff <= rsp_drive_in;
   end

endmodule

>>> tb/pid_drive_checker.sv
// Drive checker for multi_channel_pid_controller_unit: mirrors the loop tables and state,
// predicts one drive per request beat and compares it with each response beat.
// Depends on mcpid_pkg.
module pid_drive_checker
   import mcpid_pkg::*;
#(
   parameter int NUM_LOOPS = 3
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_ready,
   input  logic [1:0]               req_channel,
   input  logic [15:0]              req_target,
   input  logic [15:0]              req_measured,
   input  logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  logic signed [WORD_W-1:0] rsp_drive,
   input  logic                     csr_wr_en,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [CFG_W-1:0]         csr_wdata,
   output int                       drive_mismatches,
   output int                       drives_in_flight
);

   localparam longint FINE_D_SCALE   = 10;
   localparam longint COARSE_D_SCALE = 5;

   logic [CFG_W-1:0]         loop_tables [0:6];
   longint                   integ_acc [0:2];
   longint                   prev_err [0:2];
   logic signed [WORD_W-1:0] drive_queue [$];
   logic signed [WORD_W-1:0] want_drive;
   int                       mismatch_total = 0;

   function automatic longint loop_word(input csr_reg_type reg_id, input logic [1:0] ch);
      logic signed [WORD_W-1:0] w;
      w = loop_tables[reg_id][WORD_W*ch +: WORD_W];
      return w;
   endfunction

   function automatic logic signed [WORD_W-1:0] compute_drive(input logic [1:0]  ch,
                                                               input logic [15:0] tgt,
                                                               input logic [15:0] meas);
      longint err, kp, ki, kd, i_floor, d_floor, ceiling, o_floor, p, acc, d, sum;
      if (ch >= NUM_LOOPS) begin
         return '0;
      end
      kp      = loop_word(REG_KP, ch);
      ki      = loop_word(REG_KI, ch);
      kd      = loop_word(REG_KD, ch);
      i_floor = loop_word(REG_IFLOOR, ch);
      d_floor = loop_word(REG_DFLOOR, ch);
      ceiling = loop_word(REG_CEIL, ch);
      o_floor = loop_word(REG_OFLOOR, ch);

      err = longint'(tgt) - longint'(meas);
      p   = err * kp;

      acc = integ_acc[ch] + err * ki;
      if (acc < i_floor) acc = i_floor;
      if (acc > ceiling) acc = ceiling;
      integ_acc[ch] = acc;

      // derivative gain is scheduled on the size of the error
      d = (err - prev_err[ch]) * kd;
      if (err < SMALL_ERR_HI && err > SMALL_ERR_LO) begin
         d = d * FINE_D_SCALE;
      end else begin
         d = d * COARSE_D_SCALE;
      end
      if (d > ceiling) d = ceiling;
      if (d < d_floor) d = d_floor;
      prev_err[ch] = err;

      sum = p + acc + d;
      if (sum < o_floor) sum = o_floor;
      if (sum > ceiling) sum = ceiling;
      return sum[WORD_W-1:0];
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         loop_tables[REG_KP]     = RST_KP;
         loop_tables[REG_KI]     = RST_KI;
         loop_tables[REG_KD]     = RST_KD;
         loop_tables[REG_IFLOOR] = RST_IFLOOR;
         loop_tables[REG_DFLOOR] = RST_DFLOOR;
         loop_tables[REG_CEIL]   = RST_CEIL;
         loop_tables[REG_OFLOOR] = RST_OFLOOR;
         foreach (integ_acc[i]) begin
            integ_acc[i] = 0;
            prev_err[i]  = 0;
         end
         drive_queue.delete();
      end else begin
         if (req_valid && req_ready) begin
            drive_queue.push_back(compute_drive(req_channel, req_target, req_measured));
         end
         if (rsp_valid && rsp_ready) begin
            if (drive_queue.size() == 0) begin
               $error("drive beat with nothing expected: drive %0d", rsp_drive);
               mismatch_total++;
            end else begin
               want_drive = drive_queue.pop_front();
               if (rsp_drive !== want_drive) begin
                  $error("drive mismatch: expected %0d, actual %0d", want_drive, rsp_drive);
                  mismatch_total++;
               end
            end
         end
         if (csr_wr_en && csr_index <= REG_OFLOOR) begin
            loop_tables[csr_index] = csr_wdata;
            // any gain write clears every integrator
            if (csr_index <= REG_KD) begin
               foreach (integ_acc[i]) integ_acc[i] = 0;
            end
         end
      end
      drive_mismatches <= mismatch_total;
      drives_in_flight <= drive_queue.size();
   end

endmodule

>>> tb/multi_channel_pid_controller_unit_tb.sv
// Testbench top for multi_channel_pid_controller_unit: clock, reset, table programming,
// directed and random request beats with idle bursts, watchdog and verdict.
// Depends on mcpid_pkg, the RTL and pid_drive_checker.
module multi_channel_pid_controller_unit_tb;
   import mcpid_pkg::*;

   localparam int LOOPS          = 3;
   localparam int NUM_PHASES     = 14;
   localparam int PHASE_BEATS    = 125;
   localparam int SETTLE_CYCLES  = 24;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED = 3'd7;
   localparam logic [1:0]           BAD_LOOP   = 2'd3;

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     req_valid;
   logic                     req_ready;
   logic [1:0]               req_channel;
   logic [15:0]              req_target;
   logic [15:0]              req_measured;
   logic                     rsp_valid;
   logic                     rsp_ready;
   logic signed [WORD_W-1:0] rsp_drive;
   logic                     csr_wr_en;
   logic [CSR_IDX_W-1:0]     csr_index;
   logic [CFG_W-1:0]         csr_wdata;
   bit                       idle_on;
   int                       rsp_hold;
   int                       quiet_cycles;
   int                       drive_mismatches;
   int                       drives_in_flight;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   multi_channel_pid_controller_unit #(
      .NUM_LOOPS(LOOPS)
   ) u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_channel (req_channel),
      .req_target  (req_target),
      .req_measured(req_measured),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_drive   (rsp_drive),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   pid_drive_checker #(
      .NUM_LOOPS(LOOPS)
   ) u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_channel     (req_channel),
      .req_target      (req_target),
      .req_measured    (req_measured),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_drive       (rsp_drive),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .drive_mismatches(drive_mismatches),
      .drives_in_flight(drives_in_flight)
   );

   // response side stalls at random, in bursts, while idle_on is set
   always @(posedge clock) begin
      if (rsp_hold > 0) begin
         rsp_ready <= 1'b0;
         rsp_hold  <= rsp_hold - 1;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
         rsp_ready <= 1'b0;
         rsp_hold  <= $urandom_range(0, 4);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("multi_channel_pid_controller_unit_tb failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_sample(input logic [1:0] ch, input logic [15:0] tgt,
                              input logic [15:0] meas);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_channel  <= ch;
      req_target   <= tgt;
      req_measured <= meas;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic send_random_sample();
      logic [1:0]  ch;
      logic [15:0] tgt;
      logic [15:0] meas;
      ch   = ($urandom_range(0, 15) == 0) ? BAD_LOOP : 2'($urandom_range(0, LOOPS - 1));
      meas = 16'($urandom);
      case ($urandom_range(0, 5))
         0, 1: tgt = 16'($urandom);
         2, 3, 4: tgt = meas + 16'($urandom_range(0, 40)) - 16'd20;
         default: begin
            tgt  = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            meas = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
         end
      endcase
      send_sample(ch, tgt, meas);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (drives_in_flight != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // leaves csr_wr_en high; the caller drops it after the last write
   task automatic write_table(input logic [CSR_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   task automatic program_tables(input logic [CFG_W-1:0] kp, input logic [CFG_W-1:0] ki,
                                 input logic [CFG_W-1:0] kd, input logic [CFG_W-1:0] i_floor,
                                 input logic [CFG_W-1:0] d_floor,
                                 input logic [CFG_W-1:0] ceiling,
                                 input logic [CFG_W-1:0] o_floor, input bit with_gains);
      if (with_gains) begin
         write_table(REG_KP, kp);
         write_table(REG_KI, ki);
         write_table(REG_KD, kd);
      end
      write_table(REG_IFLOOR, i_floor);
      write_table(REG_DFLOOR, d_floor);
      write_table(REG_CEIL, ceiling);
      write_table(REG_OFLOOR, o_floor);
      write_table(REG_UNUSED, CFG_W'({$urandom, $urandom}));
      csr_wr_en <= 1'b0;
   endtask

   function automatic logic [WORD_W-1:0] rand_word();
      case ($urandom_range(0, 3))
         0: return WORD_W'($urandom);
         1: return WORD_W'($urandom_range(0, 400) - 200);
         2: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
         default: return WORD_W'($urandom_range(0, 60));
      endcase
   endfunction

   function automatic logic [CFG_W-1:0] rand_table();
      return {rand_word(), rand_word(), rand_word()};
   endfunction

   initial begin
      logic [15:0] dir_tgt [0:6];
      logic [15:0] dir_meas [0:6];
      int          ch;
      int          i;
      int          phase;
      reset        <= 1'b1;
      req_valid    <= 1'b0;
      req_channel  <= '0;
      req_target   <= '0;
      req_measured <= '0;
      rsp_ready    <= 1'b1;
      csr_wr_en    <= 1'b0;
      csr_index    <= '0;
      csr_wdata    <= '0;
      idle_on      <= 1'b1;
      // full-scale errors, equal inputs, and both sides of the small-error band
      dir_tgt  = '{16'h0000, 16'hFFFF, 16'hFFFF, 16'd1014, 16'd1015, 16'd1000, 16'd1000};
      dir_meas = '{16'hFFFF, 16'h0000, 16'hFFFF, 16'd1000, 16'd1000, 16'd1014, 16'd1015};
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      for (ch = 0; ch < LOOPS; ch++) begin
         for (i = 0; i < 7; i++) begin
            send_sample(2'(ch), dir_tgt[i], dir_meas[i]);
         end
      end
      send_sample(BAD_LOOP, 16'hFFFF, 16'h0000);
      send_sample(BAD_LOOP, 16'h0000, 16'hFFFF);
      drain_results();

      for (phase = 0; phase < NUM_PHASES; phase++) begin
         case (phase)
            0: program_tables({3{16'h7FFF}}, {3{16'h7FFF}}, {3{16'h7FFF}}, {3{16'h8000}},
                              {3{16'h8000}}, {3{16'h7FFF}}, {3{16'h8000}}, 1'b1);
            1: program_tables({3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}},
                              {3{16'h8000}}, {3{16'h7FFF}}, {3{16'h8000}}, 1'b1);
            // floors above the ceiling
            2: program_tables(rand_table(), rand_table(), rand_table(), {3{16'h0100}},
                              {3{16'h0100}}, {3{16'hFF00}}, {3{16'h0100}}, 1'b1);
            3: program_tables('0, '0, '0, '0, '0, '0, '0, 1'b1);
            default: program_tables(rand_table(), rand_table(), rand_table(), rand_table(),
                                    rand_table(), rand_table(), rand_table(), phase % 2 == 0);
         endcase
         idle_on <= (phase < NUM_PHASES - 2) && (phase % 3 != 2);
         repeat (PHASE_BEATS) send_random_sample();
         drain_results();
      end

      if (drive_mismatches == 0) begin
         $display("multi_channel_pid_controller_unit_tb passed");
      end else begin
         $display("multi_channel_pid_controller_unit_tb failed");
      end
      $finish;
   end

endmodule

>>> sim.f
rtl/core/mcpid_pkg.sv
rtl/core/mcpid_alu.sv
rtl/core/mcpid_csr.sv
rtl/core/multi_channel_pid_controller_unit.sv
tb/pid_drive_checker.sv
tb/multi_channel_pid_controller_unit_tb.sv
